FILE: rtl/mps_pkg.sv
package mps_pkg;

  localparam int NumCoresDef   = 4;
  localparam int QueueDepthDef = 16;

  // one process word as kept in the ready list, the blocked stack and a core slot
  typedef struct packed {
    logic [15:0] ram;
    logic [2:0]  prio;
    logic [7:0]  id;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_RUN       = 3'd1,
    OP_BLOCK     = 3'd2,
    OP_UNBLOCK   = 3'd3,
    OP_TERMINATE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_CORE      = 3'd1,
    ST_CORE_BUSY     = 3'd2,
    ST_CORE_EMPTY    = 3'd3,
    ST_READY_EMPTY   = 3'd4,
    ST_BLOCKED_EMPTY = 3'd5,
    ST_NO_RAM        = 3'd6,
    ST_FULL          = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SH_RD,
    S_SH_WR,
    S_RUN_HEAD,
    S_RUN_RD,
    S_RUN_WR,
    S_UB_WR
  } state_t;

  // core slot update from the controller
  typedef struct packed {
    logic       en;
    logic [2:0] idx;
    logic       valid;
    entry_t     entry;
  } slot_wr_t;

  // core slot as seen by the controller
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

endpackage

FILE: rtl/mps_ram.sv
module mps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mps_cores.sv
module mps_cores #(
  parameter int NUM_CORES = mps_pkg::NumCoresDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [2:0]       rd_idx,
  output mps_pkg::slot_t   rd_slot,
  input  mps_pkg::slot_wr_t wr
);

  localparam int IdxW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  logic           valid_r [NUM_CORES];
  mps_pkg::entry_t entry_r [NUM_CORES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CORES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (wr.en && (32'(wr.idx) < NUM_CORES)) begin
      valid_r[wr.idx[IdxW-1:0]] <= wr.valid;
    end
    if (wr.en && (32'(wr.idx) < NUM_CORES)) begin
      entry_r[wr.idx[IdxW-1:0]] <= wr.entry;
    end
  end

  always_comb begin
    rd_slot = '0;
    if (32'(rd_idx) < NUM_CORES) begin
      rd_slot.valid = valid_r[rd_idx[IdxW-1:0]];
      rd_slot.entry = entry_r[rd_idx[IdxW-1:0]];
    end
  end

endmodule

FILE: rtl/multicore_priority_ready_scheduler_core.sv
// Process scheduler: a ready list kept in priority order by add (unblock
// appends at its tail) and a LIFO blocked stack, each in a one-port-read
// synchronous RAM, plus a slot per core and a free RAM counter. A command is
// taken when start is high and busy is low; its single result word shows on
// the out_ ports for exactly one cycle with out_valid high, and the receiver
// cannot stall it. Block, terminate and any rejected command answer in the
// cycle after acceptance; unblock reads the blocked top and answers from
// S_UB_WR. Add reads the ready RAM entry by entry to find the insert point,
// moves the tail up one entry at a time and writes the new entry. Run reads
// the head into the core slot and moves the rest down. All of these go
// through the single ready RAM port pair. busy stays high until the result
// is registered; a new command may then be taken while the previous result
// is still on the output.
module multicore_priority_ready_scheduler_core #(
  parameter int NUM_CORES   = mps_pkg::NumCoresDef,
  parameter int QUEUE_DEPTH = mps_pkg::QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_proc_id,
  input  logic [2:0]  in_proc_priority,
  input  logic [15:0] in_proc_ram,
  input  logic [2:0]  in_core_index,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_moved_id,
  output logic [15:0] out_free_ram_now
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  mps_pkg::state_t state_r, state_nxt;
  mps_pkg::entry_t ent_r, ent_nxt;
  logic [2:0]      core_r, core_nxt;
  logic [CW-1:0]   rcount_r, rcount_nxt;
  logic [CW-1:0]   bcount_r, bcount_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;   // also the run shift pointer
  logic [CW-1:0]   sh_r, sh_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [15:0]     free_ram_r, free_ram_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_status_r, out_status_nxt;
  logic [7:0]      out_moved_r, out_moved_nxt;
  logic [15:0]     out_free_r;

  // ready list RAM
  logic            r_we;
  logic [AW-1:0]   r_waddr, r_raddr;
  mps_pkg::entry_t r_wdata, r_rdata;
  // blocked stack RAM
  logic            b_we;
  logic [AW-1:0]   b_waddr, b_raddr;
  mps_pkg::entry_t b_wdata, b_rdata;

  mps_pkg::slot_t    slot;
  mps_pkg::slot_wr_t slot_wr;
  logic [2:0]        slot_idx;
  logic              core_bad;
  logic [16:0]       ram_sum;

  mps_ram #(.WIDTH(mps_pkg::EntryW), .DEPTH(QUEUE_DEPTH)) u_ready_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  mps_ram #(.WIDTH(mps_pkg::EntryW), .DEPTH(QUEUE_DEPTH)) u_blocked_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mps_cores #(.NUM_CORES(NUM_CORES)) u_cores (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (slot_idx),
    .rd_slot (slot),
    .wr      (slot_wr)
  );

  // slot lookup: input index on acceptance, latched index afterwards
  assign slot_idx = (state_r == mps_pkg::S_IDLE) ? in_core_index : core_r;
  assign core_bad = 32'(in_core_index) >= NUM_CORES;
  assign ram_sum  = {1'b0, free_ram_r} + {1'b0, slot.entry.ram};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mps_pkg::S_IDLE;
      rcount_r    <= '0;
      bcount_r    <= '0;
      free_ram_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rcount_r    <= rcount_nxt;
      bcount_r    <= bcount_nxt;
      free_ram_r  <= free_ram_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ent_r        <= ent_nxt;
    core_r       <= core_nxt;
    scan_r       <= scan_nxt;
    sh_r         <= sh_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_moved_r  <= out_moved_nxt;
    out_free_r   <= free_ram_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    ent_nxt        = ent_r;
    core_nxt       = core_r;
    rcount_nxt     = rcount_r;
    bcount_nxt     = bcount_r;
    scan_nxt       = scan_r;
    sh_nxt         = sh_r;
    pos_nxt        = pos_r;
    free_ram_nxt   = free_ram_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_moved_nxt  = out_moved_r;
    r_we           = 1'b0;
    r_waddr        = '0;
    r_wdata        = ent_r;
    r_raddr        = '0;
    b_we           = 1'b0;
    b_waddr        = bcount_r[AW-1:0];
    b_wdata        = slot.entry;
    b_raddr        = '0;
    slot_wr        = '0;

    if (cfg_wr_en) begin
      free_ram_nxt = cfg_wr_data;
    end

    unique case (state_r)
      mps_pkg::S_IDLE: begin
        if (start) begin
          ent_nxt        = '{ram: in_proc_ram, prio: in_proc_priority, id: in_proc_id};
          core_nxt       = in_core_index;
          out_valid_nxt  = 1'b1;
          out_status_nxt = mps_pkg::ST_OK;
          out_moved_nxt  = '0;
          unique case (in_operation)
            mps_pkg::OP_ADD: begin
              if (rcount_r == DepthC) begin
                out_status_nxt = mps_pkg::ST_FULL;
              end else if (in_proc_ram > free_ram_r) begin
                out_status_nxt = mps_pkg::ST_NO_RAM;
              end else begin
                out_valid_nxt = 1'b0;
                scan_nxt      = '0;
                state_nxt     = mps_pkg::S_SCAN_RD;
              end
            end
            mps_pkg::OP_RUN: begin
              if (core_bad) begin
                out_status_nxt = mps_pkg::ST_BAD_CORE;
              end else if (slot.valid) begin
                out_status_nxt = mps_pkg::ST_CORE_BUSY;
              end else if (rcount_r == '0) begin
                out_status_nxt = mps_pkg::ST_READY_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                r_raddr       = '0;
                state_nxt     = mps_pkg::S_RUN_HEAD;
              end
            end
            mps_pkg::OP_BLOCK: begin
              if (core_bad) begin
                out_status_nxt = mps_pkg::ST_BAD_CORE;
              end else if (!slot.valid) begin
                out_status_nxt = mps_pkg::ST_CORE_EMPTY;
              end else if (bcount_r == DepthC) begin
                out_status_nxt = mps_pkg::ST_FULL;
              end else begin
                b_we          = 1'b1;
                bcount_nxt    = bcount_r + 1'b1;
                slot_wr.en    = 1'b1;
                slot_wr.idx   = in_core_index;
                slot_wr.valid = 1'b0;
                out_moved_nxt = slot.entry.id;
              end
            end
            mps_pkg::OP_UNBLOCK: begin
              if (bcount_r == '0) begin
                out_status_nxt = mps_pkg::ST_BLOCKED_EMPTY;
              end else if (rcount_r == DepthC) begin
                out_status_nxt = mps_pkg::ST_FULL;
              end else begin
                out_valid_nxt = 1'b0;
                b_raddr       = AW'(bcount_r - 1'b1);
                state_nxt     = mps_pkg::S_UB_WR;
              end
            end
            mps_pkg::OP_TERMINATE: begin
              if (core_bad) begin
                out_status_nxt = mps_pkg::ST_BAD_CORE;
              end else if (!slot.valid) begin
                out_status_nxt = mps_pkg::ST_CORE_EMPTY;
              end else begin
                slot_wr.en    = 1'b1;
                slot_wr.idx   = in_core_index;
                slot_wr.valid = 1'b0;
                free_ram_nxt  = ram_sum[16] ? 16'hFFFF : ram_sum[15:0];
                out_moved_nxt = slot.entry.id;
              end
            end
            default: begin
              // unused codes: plain ok, nothing moves
            end
          endcase
        end
      end

      // find the first entry whose priority value is above the new one
      mps_pkg::S_SCAN_RD: begin
        if (scan_r == rcount_r) begin
          pos_nxt   = scan_r;
          sh_nxt    = rcount_r;
          state_nxt = mps_pkg::S_SH_RD;
        end else begin
          r_raddr   = scan_r[AW-1:0];
          state_nxt = mps_pkg::S_SCAN_CHK;
        end
      end

      mps_pkg::S_SCAN_CHK: begin
        if (r_rdata.prio > ent_r.prio) begin
          pos_nxt   = scan_r;
          sh_nxt    = rcount_r;
          state_nxt = mps_pkg::S_SH_RD;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = mps_pkg::S_SCAN_RD;
        end
      end

      // open a gap at pos, top down
      mps_pkg::S_SH_RD: begin
        if (sh_r == pos_r) begin
          r_we           = 1'b1;
          r_waddr        = pos_r[AW-1:0];
          r_wdata        = ent_r;
          rcount_nxt     = rcount_r + 1'b1;
          free_ram_nxt   = free_ram_r - ent_r.ram;
          out_valid_nxt  = 1'b1;
          out_status_nxt = mps_pkg::ST_OK;
          out_moved_nxt  = ent_r.id;
          state_nxt      = mps_pkg::S_IDLE;
        end else begin
          r_raddr   = AW'(sh_r - 1'b1);
          state_nxt = mps_pkg::S_SH_WR;
        end
      end

      mps_pkg::S_SH_WR: begin
        r_we      = 1'b1;
        r_waddr   = sh_r[AW-1:0];
        r_wdata   = r_rdata;
        sh_nxt    = sh_r - 1'b1;
        state_nxt = mps_pkg::S_SH_RD;
      end

      mps_pkg::S_RUN_HEAD: begin
        ent_nxt       = r_rdata;
        slot_wr.en    = 1'b1;
        slot_wr.idx   = core_r;
        slot_wr.valid = 1'b1;
        slot_wr.entry = r_rdata;
        scan_nxt      = CW'(1);
        state_nxt     = mps_pkg::S_RUN_RD;
      end

      // close the gap at the head, bottom up
      mps_pkg::S_RUN_RD: begin
        if (scan_r == rcount_r) begin
          rcount_nxt     = rcount_r - 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = mps_pkg::ST_OK;
          out_moved_nxt  = ent_r.id;
          state_nxt      = mps_pkg::S_IDLE;
        end else begin
          r_raddr   = scan_r[AW-1:0];
          state_nxt = mps_pkg::S_RUN_WR;
        end
      end

      mps_pkg::S_RUN_WR: begin
        r_we      = 1'b1;
        r_waddr   = AW'(scan_r - 1'b1);
        r_wdata   = r_rdata;
        scan_nxt  = scan_r + 1'b1;
        state_nxt = mps_pkg::S_RUN_RD;
      end

      // blocked top goes to the ready tail, unsorted
      mps_pkg::S_UB_WR: begin
        r_we           = 1'b1;
        r_waddr        = rcount_r[AW-1:0];
        r_wdata        = b_rdata;
        rcount_nxt     = rcount_r + 1'b1;
        bcount_nxt     = bcount_r - 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = mps_pkg::ST_OK;
        out_moved_nxt  = b_rdata.id;
        state_nxt      = mps_pkg::S_IDLE;
      end

      default: begin
        state_nxt = mps_pkg::S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != mps_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_moved_id     = out_moved_r;
  assign out_free_ram_now = out_free_r;

endmodule
